>>> design/pwf_pkg.sv
// Shared types and constants for the position window filter.
package pwf_pkg;

    localparam int POS_W  = 24;
    localparam int MODE_W = 2;
    localparam int AXES   = 3;
    localparam int AXIS_W = 2;

    localparam logic [MODE_W-1:0] MODE_HOLD = 2'd0;
    localparam logic [MODE_W-1:0] MODE_AVG  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_TRIM = 2'd2;

    typedef logic signed [POS_W-1:0] t_pos;

    // Controller to datapath commands
    typedef struct packed {
        logic              load;      // item accepted: store sample, advance pointer
        logic              rd;        // issue one history read
        logic              first;     // this read is the newest sample of the window
        logic              norm;      // form numerator (trimmed in trim mode), split sign/magnitude
        logic              mul;       // multiply one axis by the reciprocal
        logic [AXIS_W-1:0] axis;
        logic              out_load;  // move results into the output register
        logic              trim;      // drop max and min of the window
    } t_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic filled;  // history has wrapped at least once
        logic wrap;    // next write lands in the last slot
    } t_sts;

endpackage

>>> design/pwf_ram.sv
// Generic single-write, single-read RAM with registered read data.
module pwf_ram #(
    parameter int WIDTH = 72,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> design/pwf_ctrl.sv
// Sequencer for the position window filter: handshakes, mode register, command generation.
module pwf_ctrl
    import pwf_pkg::*;
#(
    parameter int WINDOW_LEN = 8
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    input  logic              i_cfg_we,
    input  logic [MODE_W-1:0] i_cfg_wdata,
    input  t_sts              i_sts,
    output t_cmd              o_cmd
);

    localparam int CNT_W = $clog2(WINDOW_LEN);
    localparam logic [CNT_W-1:0] RD_LAST  = CNT_W'(WINDOW_LEN - 1);
    localparam logic [CNT_W-1:0] MUL_LAST = CNT_W'(AXES - 1);

    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001,
        S_READ = 7'b0000010,
        S_LAST = 7'b0000100,
        S_NORM = 7'b0001000,
        S_MUL  = 7'b0010000,
        S_FIN  = 7'b0100000,
        S_DONE = 7'b1000000
    } t_state;

    t_state            r_state, n_state;
    logic [CNT_W-1:0]  r_cnt, n_cnt;
    logic              r_out_valid, n_out_valid;
    logic [MODE_W-1:0] r_mode;
    logic              w_accept;
    logic              w_run;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign w_accept    = i_in_valid && o_in_ready;
    // filter only once history is full (including the item that fills it)
    assign w_run = (i_sts.filled || i_sts.wrap) &&
                   ((r_mode == MODE_AVG) || (r_mode == MODE_TRIM));

    always_comb begin
        o_cmd          = '0;
        o_cmd.load     = w_accept;
        o_cmd.rd       = (r_state == S_READ);
        o_cmd.first    = (r_state == S_READ) && (r_cnt == '0);
        o_cmd.norm     = (r_state == S_NORM);
        o_cmd.mul      = (r_state == S_MUL);
        o_cmd.axis     = r_cnt[AXIS_W-1:0];
        o_cmd.out_load = (r_state == S_DONE) && (!r_out_valid || i_out_ready);
        o_cmd.trim     = (r_mode == MODE_TRIM);
    end

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        unique case (r_state)
            S_IDLE: begin
                n_cnt = '0;
                if (w_accept) begin
                    n_state = w_run ? S_READ : S_DONE;
                end
            end
            S_READ: begin
                if (r_cnt == RD_LAST) begin
                    n_cnt   = '0;
                    n_state = S_LAST;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            S_LAST: n_state = S_NORM;
            S_NORM: n_state = S_MUL;
            S_MUL: begin
                if (r_cnt == MUL_LAST) begin
                    n_cnt   = '0;
                    n_state = S_FIN;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            S_FIN:  n_state = S_DONE;
            S_DONE: begin
                if (o_cmd.out_load) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end
        if (o_cmd.out_load) begin
            n_out_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
            r_mode      <= MODE_AVG;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                r_mode <= i_cfg_wdata;
            end
        end
    end

    a_run_enters_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && w_run) |=> (r_state == S_READ && r_cnt == '0))
        else $error("filtering item did not start the window read");

    a_mul_three_axes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_state == S_MUL) |-> ##3 (r_state == S_FIN))
        else $error("multiply phase did not cover three axes");

    a_done_entry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_state == S_DONE) |-> ($past(r_state) == S_IDLE || $past(r_state) == S_FIN))
        else $error("result stage entered from an unexpected state");

endmodule

>>> design/pwf_dp.sv
// Datapath: history RAM, window accumulate, trim, reciprocal divide, output register.
module pwf_dp
    import pwf_pkg::*;
#(
    parameter int HISTORY_DEPTH = 64,
    parameter int WINDOW_LEN    = 8
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_cmd       i_cmd,
    output t_sts       o_sts,
    input  t_pos       i_pos_x,
    input  t_pos       i_pos_y,
    input  t_pos       i_pos_z,
    output t_pos       o_filt_x,
    output t_pos       o_filt_y,
    output t_pos       o_filt_z,
    output logic       o_ready_res
);

    localparam int AW     = $clog2(HISTORY_DEPTH);
    localparam int CW     = $clog2(WINDOW_LEN);
    localparam int MAG_W  = POS_W + CW;      // |window sum| <= 2^(MAG_W-1)
    localparam int SUM_W  = MAG_W + 1;
    localparam int SH     = MAG_W + CW;      // reciprocal scale
    localparam int REC_W  = MAG_W + 3;
    localparam int PROD_W = MAG_W + REC_W;
    localparam int WORD_W = AXES * POS_W;

    // floor(2^SH / d) + 1 gives an exact floor quotient for dividends below 2^MAG_W
    localparam logic [63:0] SCALE      = 64'd1 << SH;
    localparam logic [63:0] REC_AVG64  = SCALE / 64'(WINDOW_LEN) + 64'd1;
    localparam logic [63:0] REC_TRIM64 = SCALE / 64'(WINDOW_LEN - 2) + 64'd1;
    localparam logic [REC_W-1:0] REC_AVG  = REC_AVG64[REC_W-1:0];
    localparam logic [REC_W-1:0] REC_TRIM = REC_TRIM64[REC_W-1:0];
    localparam logic [AW-1:0]    PTR_LAST = AW'(HISTORY_DEPTH - 1);

    logic [AW-1:0]             r_wr_ptr;
    logic [AW-1:0]             r_rd_ptr;
    logic                      r_filled;
    logic [WORD_W-1:0]         w_rdata;
    logic                      r_acc_vld;
    logic                      r_acc_first;
    t_pos                      w_rd   [AXES];
    logic signed [SUM_W-1:0]   r_sum  [AXES];
    t_pos                      r_hi   [AXES];
    t_pos                      r_lo   [AXES];
    logic signed [SUM_W-1:0]   w_num  [AXES];
    logic signed [SUM_W-1:0]   w_abs  [AXES];
    logic [MAG_W-1:0]          r_mag  [AXES];
    logic                      r_neg  [AXES];
    logic [PROD_W-1:0]         r_prod;
    logic                      r_mul_vld;
    logic [AXIS_W-1:0]         r_mul_axis;
    logic [POS_W-1:0]          w_q;
    t_pos                      r_filt [AXES];
    t_pos                      r_out_x, r_out_y, r_out_z;
    logic                      r_out_ready;

    pwf_ram #(
        .WIDTH (WORD_W),
        .DEPTH (HISTORY_DEPTH)
    ) u_hist (
        .i_clk   (i_clk),
        .i_we    (i_cmd.load),
        .i_waddr (r_wr_ptr),
        .i_wdata ({i_pos_z, i_pos_y, i_pos_x}),
        .i_re    (i_cmd.rd),
        .i_raddr (r_rd_ptr),
        .o_rdata (w_rdata)
    );

    assign o_sts.filled = r_filled;
    assign o_sts.wrap   = (r_wr_ptr == PTR_LAST);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr    <= '0;
            r_filled    <= 1'b0;
            r_acc_vld   <= 1'b0;
            r_acc_first <= 1'b0;
            r_mul_vld   <= 1'b0;
        end else begin
            r_acc_vld   <= i_cmd.rd;
            r_acc_first <= i_cmd.first;
            r_mul_vld   <= i_cmd.mul;
            if (i_cmd.load) begin
                if (r_wr_ptr == PTR_LAST) begin
                    r_wr_ptr <= '0;
                    r_filled <= 1'b1;
                end else begin
                    r_wr_ptr <= r_wr_ptr + 1'b1;
                end
            end
        end
    end

    // window walks backward from the slot just written
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_rd_ptr <= r_wr_ptr;
        end else if (i_cmd.rd) begin
            r_rd_ptr <= (r_rd_ptr == '0) ? PTR_LAST : r_rd_ptr - 1'b1;
        end
    end

    always_comb begin
        for (int a = 0; a < AXES; a++) begin
            w_rd[a] = w_rdata[a*POS_W +: POS_W];
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_acc_vld) begin
            for (int a = 0; a < AXES; a++) begin
                if (r_acc_first) begin
                    r_sum[a] <= SUM_W'(w_rd[a]);
                    r_hi[a]  <= w_rd[a];
                    r_lo[a]  <= w_rd[a];
                end else begin
                    r_sum[a] <= r_sum[a] + SUM_W'(w_rd[a]);
                    if (w_rd[a] > r_hi[a]) begin
                        r_hi[a] <= w_rd[a];
                    end
                    if (w_rd[a] < r_lo[a]) begin
                        r_lo[a] <= w_rd[a];
                    end
                end
            end
        end
    end

    always_comb begin
        for (int a = 0; a < AXES; a++) begin
            w_num[a] = r_sum[a];
            if (i_cmd.trim) begin
                w_num[a] = r_sum[a] - SUM_W'(r_hi[a]) - SUM_W'(r_lo[a]);
            end
            w_abs[a] = w_num[a][SUM_W-1] ? -w_num[a] : w_num[a];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.norm) begin
            for (int a = 0; a < AXES; a++) begin
                r_mag[a] <= w_abs[a][MAG_W-1:0];
                r_neg[a] <= w_num[a][SUM_W-1];
            end
        end
    end

    // one shared multiplier, one axis per cycle; divide truncates toward zero
    always_ff @(posedge i_clk) begin
        if (i_cmd.mul) begin
            r_prod     <= PROD_W'(r_mag[i_cmd.axis]) *
                          PROD_W'(i_cmd.trim ? REC_TRIM : REC_AVG);
            r_mul_axis <= i_cmd.axis;
        end
    end

    assign w_q = r_prod[SH +: POS_W];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int a = 0; a < AXES; a++) begin
                r_filt[a] <= '0;
            end
        end else if (r_mul_vld) begin
            r_filt[r_mul_axis] <= r_neg[r_mul_axis] ? -w_q : w_q;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_x     <= r_filt[0];
            r_out_y     <= r_filt[1];
            r_out_z     <= r_filt[2];
            r_out_ready <= r_filled;
        end
    end

    assign o_filt_x    = r_out_x;
    assign o_filt_y    = r_out_y;
    assign o_filt_z    = r_out_z;
    assign o_ready_res = r_out_ready;

endmodule

>>> design/position_window_filter_core.sv
// Position window filter: one x,y,z sample per item is stored in a circular history RAM and,
// once the history has wrapped, the newest WINDOW_LEN samples per axis are averaged (mode 1)
// or averaged with one maximum and one minimum dropped (mode 2); mode 0 or 3 repeats the last
// filtered values. A filtering item reads the window one RAM word per cycle, then divides
// each axis by a reciprocal multiply on one shared multiplier; a holding item skips both.
// Results sit in an output register, so the next item is accepted while a result waits.
// The history RAM needs no clearing: filtering starts only after every entry was written.
module position_window_filter_core
    import pwf_pkg::*;
#(
    parameter int HISTORY_DEPTH = 64,
    parameter int WINDOW_LEN    = 8
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  t_pos              i_pos_x,
    input  t_pos              i_pos_y,
    input  t_pos              i_pos_z,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output t_pos              o_filt_x,
    output t_pos              o_filt_y,
    output t_pos              o_filt_z,
    output logic              o_ready_res,
    input  logic              i_cfg_we,
    input  logic [MODE_W-1:0] i_cfg_wdata
);

    t_cmd w_cmd;
    t_sts w_sts;

    pwf_ctrl #(
        .WINDOW_LEN (WINDOW_LEN)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_sts       (w_sts),
        .o_cmd       (w_cmd)
    );

    pwf_dp #(
        .HISTORY_DEPTH (HISTORY_DEPTH),
        .WINDOW_LEN    (WINDOW_LEN)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_sts       (w_sts),
        .i_pos_x     (i_pos_x),
        .i_pos_y     (i_pos_y),
        .i_pos_z     (i_pos_z),
        .o_filt_x    (o_filt_x),
        .o_filt_y    (o_filt_y),
        .o_filt_z    (o_filt_z),
        .o_ready_res (o_ready_res)
    );

endmodule
